// ===== rtl/core/radio_api_frame_decoder_macros.svh =====
// Assertion macros for the radio API frame decoder.
`ifndef RADIO_API_FRAME_DECODER_MACROS_SVH
`define RADIO_API_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radio_api_frame_decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RAFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radio_api_frame_decoder: next-cycle check failed");

`endif

// ===== rtl/core/rafd_pkg.sv =====
// Types and constants shared by the radio API frame decoder.
`timescale 1ns / 1ps

package rafd_pkg;

    localparam logic [7:0] START_DELIM   = 8'h7E;
    localparam logic [7:0] API_RX16      = 8'h81;
    localparam logic [7:0] API_TX_STATUS = 8'h89;
    localparam logic [7:0] API_AT_RESP   = 8'h88;
    localparam logic [7:0] SUM_GOOD      = 8'hFF;

    localparam logic [15:0] RX_HEADER_LEN = 16'd5;
    localparam logic [15:0] TX_STATUS_LEN = 16'd3;
    localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd100;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD,
        KIND_RX_END,
        KIND_TX_STATUS,
        KIND_AT_RESP
    } t_kind;

    typedef enum logic [1:0] {
        ERR_OK,
        ERR_CHECKSUM,
        ERR_TOO_BIG
    } t_err;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] source_address;
        logic [7:0]  rssi;
        logic [7:0]  rx_options;
        logic [7:0]  payload_length;
        logic [7:0]  frame_id;
        logic [7:0]  status;
        logic [15:0] at_command;
        logic [1:0]  error;
    } t_result;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [COUNT_W-1:0] count;
    } t_queue_status;

endpackage

// ===== rtl/core/rafd_front.sv =====
// Front end: byte parser that classifies frame bytes and builds result beats.
`timescale 1ns / 1ps

module rafd_front import rafd_pkg::*; #(
    parameter int AT_RESPONSE_MAX = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_beat,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_max_payload,
    output logic          o_push,
    output t_result       o_result
);

    localparam logic [15:0] AT_MAX = 16'(AT_RESPONSE_MAX);

    t_phase      r_phase, n_phase;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_byte_index, n_byte_index;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_api_id, n_api_id;
    logic [15:0] r_address, n_address;
    logic [7:0]  r_rssi, n_rssi;
    logic [7:0]  r_options, n_options;
    logic [7:0]  r_frame_id, n_frame_id;
    logic [7:0]  r_status, n_status;
    logic [15:0] r_command, n_command;
    logic        r_oversize, n_oversize;

    logic        in_frame;
    logic [7:0]  sum_next;
    logic [15:0] rx_payload_len;

    assign in_frame       = r_byte_index < r_frame_length;
    assign sum_next       = r_sum + i_rx_byte;
    assign rx_payload_len = r_frame_length - RX_HEADER_LEN;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_beat && i_rx_byte == START_DELIM) begin
                    n_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                if (i_beat) begin
                    n_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                if (i_beat) begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (i_beat && !in_frame) begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_comb begin
        n_frame_length = r_frame_length;
        n_byte_index   = r_byte_index;
        n_sum          = r_sum;
        n_api_id       = r_api_id;
        n_address      = r_address;
        n_rssi         = r_rssi;
        n_options      = r_options;
        n_frame_id     = r_frame_id;
        n_status       = r_status;
        n_command      = r_command;
        n_oversize     = r_oversize;
        o_push         = 1'b0;
        o_result       = '0;
        if (i_beat) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == START_DELIM) begin
                        n_frame_length = '0;
                        n_byte_index   = '0;
                        n_sum          = '0;
                        n_api_id       = '0;
                        n_address      = '0;
                        n_rssi         = '0;
                        n_options      = '0;
                        n_frame_id     = '0;
                        n_status       = '0;
                        n_command      = '0;
                        n_oversize     = 1'b0;
                    end
                end
                PH_LEN_HI: begin
                    n_frame_length = {i_rx_byte, 8'h00};
                end
                PH_LEN_LO: begin
                    n_frame_length = {r_frame_length[15:8], i_rx_byte};
                    n_byte_index   = '0;
                end
                PH_DATA: begin
                    n_sum = sum_next;
                    if (in_frame) begin
                        n_byte_index = r_byte_index + 16'd1;
                        if (r_byte_index == 16'd0) begin
                            n_api_id = i_rx_byte;
                            if (i_rx_byte == API_RX16) begin
                                n_oversize = (r_frame_length < RX_HEADER_LEN) ||
                                             (rx_payload_len > {8'h00, i_max_payload});
                            end else if (i_rx_byte == API_TX_STATUS) begin
                                n_oversize = r_frame_length != TX_STATUS_LEN;
                            end else if (i_rx_byte == API_AT_RESP) begin
                                n_oversize = r_frame_length > AT_MAX;
                            end
                        end else if (!r_oversize) begin
                            if (r_api_id == API_RX16) begin
                                unique case (r_byte_index)
                                    16'd1: n_address = {i_rx_byte, 8'h00};
                                    16'd2: n_address = {r_address[15:8], i_rx_byte};
                                    16'd3: n_rssi    = i_rx_byte;
                                    16'd4: n_options = i_rx_byte;
                                    default: begin
                                        o_push             = 1'b1;
                                        o_result.kind      = KIND_PAYLOAD;
                                        o_result.data_byte = i_rx_byte;
                                    end
                                endcase
                            end else if (r_api_id == API_TX_STATUS) begin
                                if (r_byte_index == 16'd1) begin
                                    n_frame_id = i_rx_byte;
                                end else if (r_byte_index == 16'd2) begin
                                    n_status = i_rx_byte;
                                end
                            end else if (r_api_id == API_AT_RESP) begin
                                unique case (r_byte_index)
                                    16'd1: n_frame_id = i_rx_byte;
                                    16'd2: n_command  = {i_rx_byte, 8'h00};
                                    16'd3: n_command  = {r_command[15:8], i_rx_byte};
                                    16'd4: n_status   = i_rx_byte;
                                    default: ;
                                endcase
                            end
                        end
                    end else begin
                        if (r_api_id == API_RX16) begin
                            o_push        = 1'b1;
                            o_result.kind = KIND_RX_END;
                        end else if (r_api_id == API_TX_STATUS) begin
                            o_push        = 1'b1;
                            o_result.kind = KIND_TX_STATUS;
                        end else if (r_api_id == API_AT_RESP) begin
                            o_push        = 1'b1;
                            o_result.kind = KIND_AT_RESP;
                        end
                        if (r_oversize) begin
                            o_result.error = ERR_TOO_BIG;
                        end else begin
                            o_result.error = (sum_next == SUM_GOOD) ? ERR_OK : ERR_CHECKSUM;
                            if (r_api_id == API_RX16) begin
                                o_result.source_address = r_address;
                                o_result.rssi           = r_rssi;
                                o_result.rx_options     = r_options;
                                o_result.payload_length = rx_payload_len[7:0];
                            end else begin
                                o_result.frame_id = r_frame_id;
                                o_result.status   = r_status;
                                if (r_api_id == API_AT_RESP) begin
                                    o_result.at_command = r_command;
                                end
                            end
                        end
                        if (!o_push) begin
                            o_result = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_frame_length <= '0;
            r_byte_index   <= '0;
            r_sum          <= '0;
            r_api_id       <= '0;
            r_address      <= '0;
            r_rssi         <= '0;
            r_options      <= '0;
            r_frame_id     <= '0;
            r_status       <= '0;
            r_command      <= '0;
            r_oversize     <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_byte_index   <= n_byte_index;
            r_sum          <= n_sum;
            r_api_id       <= n_api_id;
            r_address      <= n_address;
            r_rssi         <= n_rssi;
            r_options      <= n_options;
            r_frame_id     <= n_frame_id;
            r_status       <= n_status;
            r_command      <= n_command;
            r_oversize     <= n_oversize;
        end
    end

endmodule

// ===== rtl/core/rafd_queue.sv =====
// Back end: result queue that holds beats until the consumer takes them.
`timescale 1ns / 1ps

module rafd_queue import rafd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_result,
    input  logic          i_pop,
    output t_result       o_head,
    output t_queue_status o_status
);

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign do_push = i_push && (r_count != COUNT_W'(QUEUE_DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + COUNT_W'(1);
            2'b01:   n_count = r_count - COUNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == COUNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_status.count = r_count;

endmodule

// ===== rtl/core/radio_api_frame_decoder.sv =====
// A result beat is written into the result queue at the clock edge that accepts the byte that causes it.
// Throughput: one byte per cycle while the result queue is not full; o_ready drops when it is full.
// A four-beat result queue lets the parser run on while the consumer stalls.
// Reset: synchronous, active low; parser hunts for a start delimiter, queue empties,
// max_payload returns to 100.
`timescale 1ns / 1ps
`include "radio_api_frame_decoder_macros.svh"

module radio_api_frame_decoder import rafd_pkg::*; #(
    parameter int AT_RESPONSE_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_source_address,
    output logic [7:0]  o_rssi,
    output logic [7:0]  o_rx_options,
    output logic [7:0]  o_payload_length,
    output logic [7:0]  o_frame_id,
    output logic [7:0]  o_status,
    output logic [15:0] o_at_command,
    output logic [1:0]  o_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]         r_max_payload;
    logic               in_beat;
    logic               push;
    logic               pop;
    t_result            front_result;
    t_result            head;
    t_queue_status      q_status;
    logic               payload_clean;
    logic               too_big_clean;
    logic [COUNT_W-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_payload <= i_cfg_data;
        end
    end

    assign o_ready = !q_status.full;
    assign in_beat = i_valid && o_ready;
    assign o_valid = !q_status.empty;
    assign pop     = o_valid && i_ready;

    rafd_front #(
        .AT_RESPONSE_MAX(AT_RESPONSE_MAX)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (in_beat),
        .i_rx_byte     (i_rx_byte),
        .i_max_payload (r_max_payload),
        .o_push        (push),
        .o_result      (front_result)
    );

    rafd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_result),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    assign o_kind           = head.kind;
    assign o_data_byte      = head.data_byte;
    assign o_source_address = head.source_address;
    assign o_rssi           = head.rssi;
    assign o_rx_options     = head.rx_options;
    assign o_payload_length = head.payload_length;
    assign o_frame_id       = head.frame_id;
    assign o_status         = head.status;
    assign o_at_command     = head.at_command;
    assign o_error          = head.error;

    assign payload_clean = o_error == ERR_OK && o_source_address == 16'd0 &&
                           o_at_command == 16'd0;
    assign too_big_clean = o_frame_id == 8'd0 && o_status == 8'd0 &&
                           o_payload_length == 8'd0 && o_data_byte == 8'd0;
    assign q_count       = q_status.count;

    `RAFD_ASSERT_IMP(a_payload_clean, i_clk, i_rst_n, o_valid && o_kind == KIND_PAYLOAD, payload_clean)
    `RAFD_ASSERT_IMP(a_too_big_clean, i_clk, i_rst_n, o_valid && o_error == ERR_TOO_BIG, too_big_clean)
    `RAFD_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, push && !pop, q_count == $past(q_count) + COUNT_W'(1))
    `RAFD_ASSERT_NEXT(a_cnt_dn, i_clk, i_rst_n, pop && !push, q_count == $past(q_count) - COUNT_W'(1))

endmodule
